// File: sv/qph_pkg.sv
// ----------------------------------------------------------------------------
// qph_pkg: shared types and constants for the quadratic probe hash table
// Transaction structs, operation codes and fixed arithmetic constants.
// ----------------------------------------------------------------------------
package qph_pkg;

    // operation codes
    localparam logic [1:0] KIND_INSERT = 2'd0;
    localparam logic [1:0] KIND_DELETE = 2'd1;
    localparam logic [1:0] KIND_SEARCH = 2'd2;

    // reciprocal of ten, scaled by 2^35
    localparam logic [31:0] RECIP_TEN  = 32'hCCCC_CCCD;

    // bucket count register width and reset value
    localparam int          CFG_W      = 11;
    localparam logic [10:0] CFG_RESET  = 11'd1024;

    typedef struct packed {
        logic [1:0]  kind;
        logic [30:0] key;
    } in_t;

    typedef struct packed {
        logic        success;
        logic [9:0]  slot;
    } out_t;

endpackage

// File: sv/quadratic_probe_hash_table_core.sv
// ----------------------------------------------------------------------------
// quadratic_probe_hash_table_core: open-addressing table, quadratic probing
// Fold hash over three-digit groups, then probes (h + i*i) mod n in memory.
// ----------------------------------------------------------------------------
// Steps: split the key into decimal digits, fold them in three-digit groups
//   with a mod-n reduction per group, probe up to n slots, then register the
//   result; key 0 probes from slot 0, and an unused kind is answered from idle.
// Throughput: one transaction at a time; for insert, delete and search, busy stays high until the result.
// Reset: bucket count 1024, then the slot memory is swept empty one entry a
//   cycle with busy high; the receiver cannot stall.
module quadratic_probe_hash_table_core
    import qph_pkg::*;
#(
    parameter int MAX_BUCKETS = 1024
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    output logic               busy,
    input  in_t                op,
    output logic               done,
    output out_t               result,
    input  logic               cfg_valid,
    output logic               cfg_ready,
    input  logic [CFG_W-1:0]   cfg_data
);

    localparam int AW = (MAX_BUCKETS > 1) ? $clog2(MAX_BUCKETS) : 1;

    typedef enum logic [2:0] {
        S_CLEAR, S_IDLE, S_DMUL, S_DSUB, S_GRP, S_MOD, S_PRD, S_PCHK
    } state_t;

    state_t              state_reg;
    logic [CFG_W-1:0]    cfg_reg;
    logic [1:0]          kind_reg;
    logic [30:0]         key_reg;
    logic [30:0]         x_reg;
    logic [63:0]         prod_reg;
    logic [3:0]          dig_reg [10];
    logic [3:0]          cnt_reg;
    logic [3:0]          pos_reg;
    logic [1:0]          take_reg;
    logic                last_reg;
    logic [9:0]          grp_reg;
    logic [11:0]         rem_reg;
    logic [3:0]          k_reg;
    logic [CFG_W-1:0]    home_reg;
    logic [CFG_W-1:0]    sqm_reg;
    logic [CFG_W-1:0]    d_reg;
    logic [CFG_W-1:0]    slot_reg;
    logic [CFG_W-1:0]    i_reg;
    logic [AW-1:0]       clr_reg;
    logic                done_reg;
    out_t                result_reg;

    logic [31:0]         mem [MAX_BUCKETS];
    logic [31:0]         rdata_reg;
    logic                mem_we;
    logic [AW-1:0]       mem_waddr;
    logic [31:0]         mem_wdata;

    logic [CFG_W-1:0]    n_eff;
    logic [27:0]         q_next;
    logic [30:0]         tenq;
    logic [3:0]          digit_next;
    logic [9:0]          grp_next;
    logic [22:0]         sh_next;
    logic [11:0]         rem_next;
    logic                hit;
    logic [CFG_W:0]      sqm_sum;
    logic [CFG_W-1:0]    sqm_next;
    logic [CFG_W+1:0]    d_sum;
    logic [CFG_W+1:0]    d_part;
    logic [CFG_W-1:0]    d_next;
    logic [CFG_W:0]      slot_sum;
    logic [CFG_W-1:0]    slot_next;

    // effective bucket count: zero acts as one, clamp to capacity
    always_comb
    begin
        if (cfg_reg == '0)
            n_eff = CFG_W'(1);
        else if (32'(cfg_reg) > MAX_BUCKETS)
            n_eff = CFG_W'(MAX_BUCKETS);
        else
            n_eff = cfg_reg;
    end

    // digit split: quotient by ten from the registered product
    assign q_next     = prod_reg[62:35];
    assign tenq       = 31'({q_next, 3'b000}) + 31'({q_next, 1'b0});
    assign digit_next = 4'(x_reg - tenq);
    assign grp_next   = 10'(grp_reg * 10'd10) + 10'(dig_reg[pos_reg]);

    // one restoring step of the modulo reduction
    assign sh_next  = 23'(n_eff) << k_reg;
    assign rem_next = (23'(rem_reg) >= sh_next) ? 12'(23'(rem_reg) - sh_next) : rem_reg;

    // probe compare
    always_comb
    begin
        case (kind_reg)
            KIND_INSERT: hit = !rdata_reg[31];
            default:     hit = rdata_reg[31] && (rdata_reg[30:0] == key_reg);
        endcase
    end

    // next probe offsets: i^2 mod n and (2i+1) mod n, kept incrementally
    always_comb
    begin
        sqm_sum  = {1'b0, sqm_reg} + {1'b0, d_reg};
        sqm_next = (sqm_sum >= {1'b0, n_eff}) ? CFG_W'(sqm_sum - {1'b0, n_eff})
                                              : CFG_W'(sqm_sum);
        d_sum    = {2'b00, d_reg} + (CFG_W+2)'(2);
        d_part   = (d_sum >= {2'b00, n_eff}) ? d_sum - {2'b00, n_eff} : d_sum;
        d_next   = (d_part >= {2'b00, n_eff}) ? CFG_W'(d_part - {2'b00, n_eff})
                                              : CFG_W'(d_part);
        slot_sum = {1'b0, home_reg} + {1'b0, sqm_next};
        slot_next = (slot_sum >= {1'b0, n_eff}) ? CFG_W'(slot_sum - {1'b0, n_eff})
                                                : CFG_W'(slot_sum);
    end

    // memory write: clearing sweep or probe hit on insert/delete
    always_comb
    begin
        mem_we    = 1'b0;
        mem_waddr = AW'(slot_reg);
        mem_wdata = {1'b0, key_reg};
        if (state_reg == S_CLEAR)
        begin
            mem_we    = 1'b1;
            mem_waddr = clr_reg;
            mem_wdata = '0;
        end
        else if (state_reg == S_PCHK && hit && kind_reg != KIND_SEARCH)
        begin
            mem_we    = 1'b1;
            mem_wdata = {kind_reg == KIND_INSERT, key_reg};
        end
    end

    // slot memory
    always_ff @(posedge clk)
    begin
        if (mem_we)
            mem[mem_waddr] <= mem_wdata;
        rdata_reg <= mem[AW'(slot_reg)];
    end

    // sequencer
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_CLEAR;
            cfg_reg   <= CFG_RESET;
            clr_reg   <= '0;
            done_reg  <= 1'b0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (cfg_valid)
                cfg_reg <= cfg_data;
            case (state_reg)
                S_CLEAR:
                begin
                    clr_reg <= clr_reg + AW'(1);
                    if (clr_reg == AW'(MAX_BUCKETS - 1))
                        state_reg <= S_IDLE;
                end
                S_IDLE:
                begin
                    if (start)
                    begin
                        kind_reg <= op.kind;
                        key_reg  <= op.key;
                        x_reg    <= op.key;
                        cnt_reg  <= '0;
                        if (op.kind != KIND_INSERT && op.kind != KIND_DELETE &&
                            op.kind != KIND_SEARCH)
                        begin
                            done_reg   <= 1'b1;
                            result_reg <= '0;
                        end
                        else if (op.key == '0)
                        begin
                            home_reg  <= '0;
                            slot_reg  <= '0;
                            sqm_reg   <= '0;
                            d_reg     <= (n_eff == CFG_W'(1)) ? '0 : CFG_W'(1);
                            i_reg     <= '0;
                            state_reg <= S_PRD;
                        end
                        else
                            state_reg <= S_DMUL;
                    end
                end
                S_DMUL:
                begin
                    prod_reg  <= 64'(x_reg) * 64'(RECIP_TEN);
                    state_reg <= S_DSUB;
                end
                S_DSUB:
                begin
                    dig_reg[cnt_reg] <= digit_next;
                    cnt_reg <= cnt_reg + 4'd1;
                    x_reg   <= 31'(q_next);
                    if (q_next == '0)
                    begin
                        pos_reg   <= cnt_reg;
                        take_reg  <= '0;
                        grp_reg   <= '0;
                        home_reg  <= '0;
                        state_reg <= S_GRP;
                    end
                    else
                        state_reg <= S_DMUL;
                end
                // build one group, most significant digit first
                S_GRP:
                begin
                    grp_reg  <= grp_next;
                    take_reg <= take_reg + 2'd1;
                    pos_reg  <= pos_reg - 4'd1;
                    if (take_reg == 2'd2 || pos_reg == '0)
                    begin
                        last_reg  <= (pos_reg == '0);
                        rem_reg   <= 12'(home_reg) + 12'(grp_next);
                        k_reg     <= 4'd11;
                        state_reg <= S_MOD;
                    end
                end
                // (sum + group) mod n, one shifted subtract a cycle
                S_MOD:
                begin
                    rem_reg <= rem_next;
                    k_reg   <= k_reg - 4'd1;
                    if (k_reg == '0)
                    begin
                        home_reg <= CFG_W'(rem_next);
                        grp_reg  <= '0;
                        take_reg <= '0;
                        if (last_reg)
                        begin
                            slot_reg  <= CFG_W'(rem_next);
                            sqm_reg   <= '0;
                            d_reg     <= (n_eff == CFG_W'(1)) ? '0 : CFG_W'(1);
                            i_reg     <= '0;
                            state_reg <= S_PRD;
                        end
                        else
                            state_reg <= S_GRP;
                    end
                end
                S_PRD:
                    state_reg <= S_PCHK;
                S_PCHK:
                begin
                    if (hit)
                    begin
                        done_reg           <= 1'b1;
                        result_reg.success <= 1'b1;
                        result_reg.slot    <= 10'(slot_reg);
                        state_reg          <= S_IDLE;
                    end
                    else if (i_reg + CFG_W'(1) == n_eff)
                    begin
                        done_reg   <= 1'b1;
                        result_reg <= '0;
                        state_reg  <= S_IDLE;
                    end
                    else
                    begin
                        i_reg     <= i_reg + CFG_W'(1);
                        sqm_reg   <= sqm_next;
                        d_reg     <= d_next;
                        slot_reg  <= slot_next;
                        state_reg <= S_PRD;
                    end
                end
                default:
                    state_reg <= S_IDLE;
            endcase
        end
    end

    assign busy      = (state_reg != S_IDLE);
    assign done      = done_reg;
    assign result    = result_reg;
    assign cfg_ready = 1'b1;

endmodule

// File: sv/qph_checker.sv
// ----------------------------------------------------------------------------
// qph_checker: port-level checks for the quadratic probe hash table
// Watches the command, result and busy ports over time.
// ----------------------------------------------------------------------------
module qph_checker
    import qph_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic start,
    input  logic busy,
    input  logic done,
    input  out_t result
);

    // a result never appears while a transaction is still running
    a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> !busy)
        else $error("result strobe while busy");

    // an accepted transaction either runs or answers at once
    a_accept: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> (busy || done))
        else $error("accepted transaction dropped");

    // a result follows work or a fresh command
    a_cause: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(busy || start))
        else $error("result with no transaction");

    // a failed result carries slot zero
    a_fail_slot: assert property (@(posedge clk) disable iff (!rst_n)
        (done && !result.success) |-> (result.slot == '0))
        else $error("failed result with nonzero slot");

endmodule

bind quadratic_probe_hash_table_core qph_checker u_qph_checker (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (start),
    .busy   (busy),
    .done   (done),
    .result (result)
);

// File: verif/testbench.sv
// ----------------------------------------------------------------------------
// testbench: self-checking bench for quadratic_probe_hash_table_core
// Drives insert, delete, search and unused-kind commands plus bucket-count writes, tracks
// a local copy of the table and compares every result field by field.
// ----------------------------------------------------------------------------
module testbench;
    import qph_pkg::*;

    localparam int MAXB = 1024;
    localparam int RAND_ITEMS = 1000;

    logic               clk;
    logic               rst_n;
    logic               start;
    logic               busy;
    in_t                op;
    logic               done;
    out_t               result;
    logic               cfg_valid;
    logic               cfg_ready;
    logic [CFG_W-1:0]   cfg_data;

    // predictor state
    logic [30:0] key_store [MAXB];
    bit          key_held [MAXB];
    logic [10:0] bucket_reg;
    out_t        pending_results [$];
    logic [30:0] live_keys [$];

    int mismatch_count;
    int item_count;
    int checked_count;
    bit gap_enable;

    // one directed stimulus row; check_now means the expected value is typed in
    typedef struct {
        logic [1:0]  kind;
        logic [30:0] key;
        bit          check_now;
        logic        exp_success;
        logic [9:0]  exp_slot;
    } row_t;

    row_t directed_rows [$];

    quadratic_probe_hash_table_core i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .busy      (busy),
        .op        (op),
        .done      (done),
        .result    (result),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)
    );

    always
    begin
        clk = 1'b0;
        #10;
        clk = 1'b1;
        #10;
    end

    task automatic report_mismatch(input string what);
        $display("MISMATCH t=%0t item %0d: %s", $realtime, checked_count, what);
        mismatch_count++;
    endtask

    function automatic int effective_buckets();
        if (bucket_reg == 0)
            return 1;
        if (bucket_reg > MAXB)
            return MAXB;
        return int'(bucket_reg);
    endfunction

    // shift folding over three-digit groups from the most significant digit
    function automatic int fold_home(logic [30:0] key, int n);
        int digs [12];
        int cnt;
        int pos;
        int grp;
        int take;
        int acc;
        logic [31:0] k;
        cnt = 0;
        acc = 0;
        k = 32'(key);
        while (k > 0)
        begin
            digs[cnt] = k % 10;
            k = k / 10;
            cnt++;
        end
        pos = cnt - 1;
        while (pos >= 0)
        begin
            grp = digs[pos];
            take = 1;
            while (take < 3 && pos > 0)
            begin
                pos--;
                grp = grp * 10 + digs[pos];
                take++;
            end
            acc = (acc + grp) % n;
            pos--;
        end
        return acc;
    endfunction

    // apply one operation to the local table and return the expected result
    function automatic out_t table_step(logic [1:0] kind, logic [30:0] key);
        out_t r;
        int n;
        int home;
        longint s;
        r = '0;
        if (kind != KIND_INSERT && kind != KIND_DELETE && kind != KIND_SEARCH)
            return r;
        n = effective_buckets();
        home = fold_home(key, n);
        for (longint i = 0; i < n; i++)
        begin
            s = (home + i * i) % n;
            if (kind == KIND_INSERT)
            begin
                if (!key_held[s])
                begin
                    key_held[s] = 1'b1;
                    key_store[s] = key;
                    r.success = 1'b1;
                    r.slot = s[9:0];
                    return r;
                end
            end
            else if (key_held[s] && key_store[s] == key)
            begin
                if (kind == KIND_DELETE)
                    key_held[s] = 1'b0;
                r.success = 1'b1;
                r.slot = s[9:0];
                return r;
            end
        end
        return r;
    endfunction

    // random idle cycles on the sending side; start drops while idling
    task automatic maybe_gap();
        while (gap_enable && $urandom_range(99) < 26)
        begin
            start <= 1'b0;
            @(posedge clk);
        end
    endtask

    // issue one command and queue its expected result
    task automatic send_op(input logic [1:0] kind, input logic [30:0] key);
        in_t item;
        maybe_gap();
        item.kind = kind;
        item.key = key;
        start <= 1'b1;
        op <= item;
        @(posedge clk);
        while (busy)
            @(posedge clk);
        pending_results.push_back(table_step(kind, key));
        if (kind == KIND_INSERT)
            live_keys.push_back(key);
        item_count++;
    endtask

    // wait for drain, then write the bucket count
    task automatic write_buckets(input logic [10:0] value);
        int guard;
        guard = 0;
        start <= 1'b0;
        while (pending_results.size() != 0 && guard < 200000)
        begin
            @(posedge clk);
            guard++;
        end
        repeat (8) @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_data <= value;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        bucket_reg = value;
        cfg_valid <= 1'b0;
    endtask

    // result checker
    always @(posedge clk)
    begin
        if (rst_n && done)
        begin
            checked_count++;
            if (pending_results.size() == 0)
                report_mismatch("result with nothing outstanding");
            else
            begin
                out_t want;
                want = pending_results.pop_front();
                if (result.success !== want.success)
                    report_mismatch($sformatf("success %b want %b",
                        result.success, want.success));
                if (result.slot !== want.slot)
                    report_mismatch($sformatf("slot %0d want %0d",
                        result.slot, want.slot));
            end
        end
    end

    function automatic logic [30:0] pick_key();
        int sel;
        sel = $urandom_range(99);
        if (sel < 55 && live_keys.size() != 0)
            return live_keys[$urandom_range(live_keys.size() - 1)];
        if (sel < 75)
            return 31'($urandom_range(999));
        if (sel < 85)
            return 31'($urandom_range(99999));
        return 31'($urandom);
    endfunction

    initial
    begin
        #1_000_000_000;
        $display("Mismatches found");
        $finish;
    end

    initial
    begin
        logic [1:0] kind;
        int drain;
        start = 1'b0;
        op = '0;
        cfg_valid = 1'b0;
        cfg_data = '0;
        rst_n = 1'b0;
        mismatch_count = 0;
        item_count = 0;
        checked_count = 0;
        gap_enable = 1'b1;
        bucket_reg = CFG_RESET;
        for (int i = 0; i < MAXB; i++)
            key_held[i] = 1'b0;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;

        // directed: empty table, extremes, every kind including unused
        directed_rows = '{
            '{KIND_SEARCH, 31'd0,          1, 1'b0, 10'd0},
            '{KIND_DELETE, 31'd5,          1, 1'b0, 10'd0},
            '{KIND_INSERT, 31'd0,          1, 1'b1, 10'd0},
            '{KIND_INSERT, 31'd0,          0, 1'b0, 10'd0},
            '{KIND_SEARCH, 31'd0,          1, 1'b1, 10'd0},
            '{KIND_INSERT, 31'h7FFFFFFF,   0, 1'b0, 10'd0},
            '{KIND_SEARCH, 31'h7FFFFFFF,   0, 1'b0, 10'd0},
            '{KIND_INSERT, 31'd123,        1, 1'b1, 10'd123},
            '{KIND_INSERT, 31'd123456,     0, 1'b0, 10'd0},
            '{2'd3,        31'd123,        1, 1'b0, 10'd0},
            '{KIND_DELETE, 31'd0,          1, 1'b1, 10'd0},
            '{KIND_SEARCH, 31'd0,          0, 1'b0, 10'd0},
            '{KIND_DELETE, 31'h7FFFFFFF,   0, 1'b0, 10'd0},
            '{KIND_SEARCH, 31'd123456,     0, 1'b0, 10'd0}
        };
        foreach (directed_rows[r])
        begin
            send_op(directed_rows[r].kind, directed_rows[r].key);
            if (directed_rows[r].check_now &&
                (pending_results[$].success !== directed_rows[r].exp_success ||
                 pending_results[$].slot !== directed_rows[r].exp_slot))
                report_mismatch($sformatf("directed row %0d disagrees", r));
        end

        // single bucket: fill, overflow, then out-of-range counts
        write_buckets(11'd1);
        send_op(KIND_INSERT, 31'd77);
        send_op(KIND_INSERT, 31'd78);
        send_op(KIND_SEARCH, 31'd77);
        write_buckets(11'd0);
        send_op(KIND_INSERT, 31'd9);
        send_op(KIND_SEARCH, 31'd0);
        write_buckets(11'h7FF);
        send_op(KIND_SEARCH, 31'd123);
        send_op(KIND_INSERT, 31'd1000);

        // random phases over several bucket counts; small tables fill up
        for (int ph = 0; ph < 8; ph++)
        begin
            case (ph)
                0: write_buckets(11'd7);
                1: write_buckets(11'd2);
                2: write_buckets(11'd1024);
                3: write_buckets(11'($urandom_range(1, 64)));
                4: write_buckets(11'd13);
                5: write_buckets(11'($urandom_range(0, 2047)));
                6: write_buckets(11'd1);
                default: write_buckets(11'd31);
            endcase
            gap_enable = (ph != 2);
            for (int i = 0; i < RAND_ITEMS / 8; i++)
            begin
                kind = 2'($urandom_range(2));
                if ($urandom_range(99) < 3)
                    kind = 2'd3;
                send_op(kind, pick_key());
                if (live_keys.size() > 64)
                    live_keys.delete(0);
            end
        end

        start <= 1'b0;
        drain = 0;
        while (pending_results.size() != 0 && drain < 200000)
        begin
            @(posedge clk);
            drain++;
        end
        repeat (200) @(posedge clk);
        if (pending_results.size() != 0)
            report_mismatch($sformatf("%0d results never arrived",
                pending_results.size()));

        $display("Ran %0d commands over bucket counts 0..2047, %0d results checked.",
            item_count, checked_count);
        if (mismatch_count == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule
